[rtl/flick_gesture_classifier_assert.svh]
// Assertion macros for the flick classifier checker.
`ifndef FLICK_GESTURE_CLASSIFIER_ASSERT_SVH
`define FLICK_GESTURE_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FGC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flick classifier check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FGC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flick classifier check failed");

`endif

[rtl/fgc_pkg.sv]
// Types and constants shared by the flick gesture classifier modules.
package fgc_pkg;

    localparam int THR_W     = 15;
    localparam int LEN_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = THR_W;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 15'd9825;
    localparam logic [LEN_W-1:0] WINDOW_RESET    = 8'd80;
    localparam logic [LEN_W-1:0] COOLDOWN_RESET  = 8'd80;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WINDOW    = 2'd1,
        CFG_COOLDOWN  = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        G_UP    = 2'd0,
        G_DOWN  = 2'd1,
        G_LEFT  = 2'd2,
        G_RIGHT = 2'd3
    } gesture_t;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_CAPTURE  = 2'd1,
        PH_COOLDOWN = 2'd2
    } phase_t;

    // Per-sample control from the sequencer to the peak trackers.
    typedef struct packed {
        logic clear;   // window opens on this sample
        logic track;   // sample takes part in a window
        logic emit;    // last sample of the window
    } fgc_ctrl_t;

endpackage

[rtl/fgc_peak.sv]
// Per-axis peak tracker: magnitude, trigger compare and running signed peak.
module fgc_peak #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic signed [SAMPLE_BITS-1:0]  sample,
    input  logic [fgc_pkg::THR_W-1:0]      threshold,
    input  fgc_pkg::fgc_ctrl_t             ctrl,
    output logic                           trigger,
    output logic signed [SAMPLE_BITS-1:0]  best_next,
    output logic [SAMPLE_BITS-1:0]         best_mag_next
);

    localparam int CMP_W = (SAMPLE_BITS > fgc_pkg::THR_W) ? SAMPLE_BITS : fgc_pkg::THR_W;

    logic signed [SAMPLE_BITS-1:0] best_reg;
    logic signed [SAMPLE_BITS-1:0] base;
    logic [SAMPLE_BITS-1:0]        base_mag;
    logic [SAMPLE_BITS-1:0]        samp_mag;
    logic                          take;

    // |most negative| still fits as an unsigned value of the same width
    assign samp_mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
    assign trigger  = CMP_W'(samp_mag) > CMP_W'(threshold);

    always_comb
    begin
        base     = ctrl.clear ? '0 : best_reg;
        base_mag = base[SAMPLE_BITS-1] ? (~base + 1'b1) : base;
        // strict compare: first sample wins a tie
        take          = samp_mag > base_mag;
        best_next     = take ? sample : base;
        best_mag_next = take ? samp_mag : base_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else if (ctrl.track)
        begin
            best_reg <= best_next;
        end
    end

endmodule

[rtl/fgc_seq.sv]
// Window / cooldown sequencer: phase state machine and sample counter.
module fgc_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic                        trigger,
    input  logic [fgc_pkg::LEN_W-1:0]   window_length,
    input  logic [fgc_pkg::LEN_W-1:0]   cooldown_length,
    output fgc_pkg::fgc_ctrl_t          ctrl
);

    fgc_pkg::phase_t              phase_reg, phase_next;
    logic [fgc_pkg::LEN_W-1:0]    count_reg, count_next;
    logic [fgc_pkg::LEN_W-1:0]    count_inc;
    logic [fgc_pkg::LEN_W-1:0]    wl_eff;
    logic                         capture_done;
    logic                         single_window;
    fgc_pkg::phase_t              after_window;

    assign count_inc     = count_reg + 1'b1;
    assign wl_eff        = (window_length == '0) ? fgc_pkg::LEN_W'(1) : window_length;
    assign capture_done  = count_inc >= wl_eff;
    assign single_window = wl_eff == fgc_pkg::LEN_W'(1);
    assign after_window  = (cooldown_length == '0) ? fgc_pkg::PH_IDLE : fgc_pkg::PH_COOLDOWN;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        if (fire)
        begin
            unique case (phase_reg)
                fgc_pkg::PH_CAPTURE:
                begin
                    if (capture_done)
                    begin
                        phase_next = after_window;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                fgc_pkg::PH_COOLDOWN:
                begin
                    if (count_inc >= cooldown_length)
                    begin
                        phase_next = fgc_pkg::PH_IDLE;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                default:
                begin
                    phase_next = fgc_pkg::PH_IDLE;
                    if (trigger)
                    begin
                        if (single_window)
                        begin
                            phase_next = after_window;
                            count_next = '0;
                        end
                        else
                        begin
                            phase_next = fgc_pkg::PH_CAPTURE;
                            count_next = fgc_pkg::LEN_W'(1);
                        end
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        ctrl = '0;
        if (fire)
        begin
            unique case (phase_reg)
                fgc_pkg::PH_CAPTURE:
                begin
                    ctrl.track = 1'b1;
                    ctrl.emit  = capture_done;
                end
                fgc_pkg::PH_COOLDOWN:
                begin
                    ctrl = '0;
                end
                default:
                begin
                    ctrl.clear = trigger;
                    ctrl.track = trigger;
                    ctrl.emit  = trigger && single_window;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= fgc_pkg::PH_IDLE;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

[rtl/flick_gesture_classifier.sv]
// Flick gesture classifier: one pitch/yaw gyro sample per cycle in, one
// classified flick out per capture window. The block sustains one sample
// per clock while m_tready keeps taking results; a sample goes through an
// input register and the update stage (magnitude, peak compare, direction
// pick) into the result register. The input register lets one more sample
// in while a result waits to be taken.
// Configuration: index 0 trigger threshold (raw counts, strict >), index 1
// window length (0 acts as 1), index 2 cooldown length in samples.
module flick_gesture_classifier #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [fgc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [fgc_pkg::CFG_DATA_W-1:0]         cfg_data,
    // sample stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,  // pitch_rate, yaw_rate
    // result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((2*SAMPLE_BITS+9)/8)*8-1:0]     m_tdata   // gesture, pitch_peak, yaw_peak
);

    localparam int OUT_W  = 2 + 2*SAMPLE_BITS;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    logic [fgc_pkg::THR_W-1:0]      threshold_reg;
    logic [fgc_pkg::LEN_W-1:0]      window_reg;
    logic [fgc_pkg::LEN_W-1:0]      cooldown_reg;

    logic                           in_valid_reg;
    logic signed [SAMPLE_BITS-1:0]  pitch_in_reg;
    logic signed [SAMPLE_BITS-1:0]  yaw_in_reg;

    logic                           out_valid_reg;
    fgc_pkg::gesture_t              gesture_reg, gesture_next;
    logic signed [SAMPLE_BITS-1:0]  pitch_out_reg;
    logic signed [SAMPLE_BITS-1:0]  yaw_out_reg;

    logic                           fire;
    logic                           s_accept;
    logic                           pitch_trig, yaw_trig;
    logic signed [SAMPLE_BITS-1:0]  pitch_best, yaw_best;
    logic [SAMPLE_BITS-1:0]         pitch_mag, yaw_mag;
    fgc_pkg::fgc_ctrl_t             ctrl;

    assign cfg_ready = 1'b1;
    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign s_accept  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= fgc_pkg::THRESHOLD_RESET;
            window_reg    <= fgc_pkg::WINDOW_RESET;
            cooldown_reg  <= fgc_pkg::COOLDOWN_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                fgc_pkg::CFG_THRESHOLD: threshold_reg <= cfg_data;
                fgc_pkg::CFG_WINDOW:    window_reg    <= cfg_data[fgc_pkg::LEN_W-1:0];
                fgc_pkg::CFG_COOLDOWN:  cooldown_reg  <= cfg_data[fgc_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            pitch_in_reg <= s_tdata[SAMPLE_BITS-1:0];
            yaw_in_reg   <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
    end

    fgc_seq u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .trigger         (pitch_trig || yaw_trig),
        .window_length   (window_reg),
        .cooldown_length (cooldown_reg),
        .ctrl            (ctrl)
    );

    fgc_peak #(.SAMPLE_BITS(SAMPLE_BITS)) u_pitch (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample        (pitch_in_reg),
        .threshold     (threshold_reg),
        .ctrl          (ctrl),
        .trigger       (pitch_trig),
        .best_next     (pitch_best),
        .best_mag_next (pitch_mag)
    );

    fgc_peak #(.SAMPLE_BITS(SAMPLE_BITS)) u_yaw (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample        (yaw_in_reg),
        .threshold     (threshold_reg),
        .ctrl          (ctrl),
        .trigger       (yaw_trig),
        .best_next     (yaw_best),
        .best_mag_next (yaw_mag)
    );

    // pitch wins a magnitude tie; a zero peak counts as not positive
    always_comb
    begin
        if (pitch_mag >= yaw_mag)
        begin
            gesture_next = (!pitch_best[SAMPLE_BITS-1] && (pitch_best != '0))
                           ? fgc_pkg::G_UP : fgc_pkg::G_DOWN;
        end
        else
        begin
            gesture_next = (!yaw_best[SAMPLE_BITS-1] && (yaw_best != '0))
                           ? fgc_pkg::G_LEFT : fgc_pkg::G_RIGHT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            gesture_reg   <= gesture_next;
            pitch_out_reg <= pitch_best;
            yaw_out_reg   <= yaw_best;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TW'({yaw_out_reg, pitch_out_reg, gesture_reg});

endmodule

[rtl/fgc_checker.sv]
// Port-level checker for the flick gesture classifier, bound to the top level.
`include "flick_gesture_classifier_assert.svh"

module fgc_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   cfg_valid,
    input logic                                   cfg_ready,
    input logic [fgc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input logic [fgc_pkg::CFG_DATA_W-1:0]         cfg_data,
    input logic                                   s_tvalid,
    input logic                                   s_tready,
    input logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [((2*SAMPLE_BITS+9)/8)*8-1:0]     m_tdata
);

    logic [1:0]                    gesture;
    logic signed [SAMPLE_BITS-1:0] pitch_peak;
    logic signed [SAMPLE_BITS-1:0] yaw_peak;
    logic [SAMPLE_BITS-1:0]        pitch_mag;
    logic [SAMPLE_BITS-1:0]        yaw_mag;
    logic [1:0]                    gesture_exp;
    logic                          cfg_seen;

    assign gesture    = m_tdata[1:0];
    assign pitch_peak = m_tdata[SAMPLE_BITS+1:2];
    assign yaw_peak   = m_tdata[2*SAMPLE_BITS+1:SAMPLE_BITS+2];
    assign pitch_mag  = pitch_peak[SAMPLE_BITS-1] ? (~pitch_peak + 1'b1) : pitch_peak;
    assign yaw_mag    = yaw_peak[SAMPLE_BITS-1] ? (~yaw_peak + 1'b1) : yaw_peak;
    assign cfg_seen   = cfg_valid && (cfg_index != '0 || cfg_data != '0 || s_tdata != '0);

    always_comb
    begin
        if (pitch_mag >= yaw_mag)
        begin
            gesture_exp = (!pitch_peak[SAMPLE_BITS-1] && pitch_peak != '0)
                          ? fgc_pkg::G_UP : fgc_pkg::G_DOWN;
        end
        else
        begin
            gesture_exp = (!yaw_peak[SAMPLE_BITS-1] && yaw_peak != '0)
                          ? fgc_pkg::G_LEFT : fgc_pkg::G_RIGHT;
        end
    end

    // a waiting result holds until it is taken
    `FGC_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // the direction always agrees with the peaks carried alongside it
    `FGC_ASSERT_NOW(a_gesture_matches_peaks, m_tvalid, gesture == gesture_exp)
    // with no result pending the sample side never stalls
    `FGC_ASSERT_NOW(a_no_stall_when_free, !m_tvalid, s_tready)
    // configuration writes are never held off
    `FGC_ASSERT_NOW(a_cfg_always_taken, cfg_seen || cfg_valid, cfg_ready)

endmodule

bind flick_gesture_classifier fgc_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_fgc_checker (.*);

[tb/flick_gesture_classifier_tb.sv]
// Self-checking testbench for the flick gesture classifier with its own window predictor.
module flick_gesture_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_BITS = 16;
    localparam int S_W         = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int M_W         = ((2*SAMPLE_BITS+9)/8)*8;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_WAIT  = 8;

    typedef struct packed {
        fgc_pkg::gesture_t  gesture;
        logic signed [15:0] pitch_peak;
        logic signed [15:0] yaw_peak;
    } flick_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [fgc_pkg::CFG_IDX_W-1:0]  cfg_index = fgc_pkg::CFG_THRESHOLD;
    logic [fgc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [S_W-1:0]                 s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [M_W-1:0]                 m_tdata;

    // predictor state and register copies
    logic [fgc_pkg::THR_W-1:0]  trig_level = fgc_pkg::THRESHOLD_RESET;
    logic [fgc_pkg::LEN_W-1:0]  window_len = fgc_pkg::WINDOW_RESET;
    logic [fgc_pkg::LEN_W-1:0]  cooldown_len = fgc_pkg::COOLDOWN_RESET;
    fgc_pkg::phase_t            flick_phase = fgc_pkg::PH_IDLE;
    logic [7:0]                 flick_count = '0;
    logic signed [15:0]         pitch_best = '0;
    logic signed [15:0]         yaw_best = '0;

    logic [S_W-1:0] pending_samples[$];
    flick_t         flick_expected_q[$];

    int  fail_count = 0;
    int  items_queued = 0;
    int  flicks_checked = 0;
    int  reg_writes = 0;
    int  quiet_cycles = 0;
    bit  idle_on = 1'b1;
    int  hold_asked = 0;
    int  hold_done = 0;
    int  hold_left = 0;
    int  stall_left = 0;
    int  gap_left = 0;
    logic s_took = 1'b0;

    flick_gesture_classifier #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 clk = ~clk;

    function automatic logic [16:0] magnitude(logic signed [15:0] v);
        logic signed [16:0] w;
        w = v;
        return (w < 0) ? 17'(-w) : 17'(w);
    endfunction

    // One sample through the idle / capture / cooldown sequence.
    task automatic predict_flick(logic signed [15:0] p, logic signed [15:0] y);
        logic [7:0] wl;
        flick_t     f;
        if (flick_phase == fgc_pkg::PH_COOLDOWN)
        begin
            flick_count = flick_count + 8'd1;
            if (flick_count >= cooldown_len)
            begin
                flick_phase = fgc_pkg::PH_IDLE;
                flick_count = '0;
            end
        end
        else
        begin
            if (flick_phase == fgc_pkg::PH_IDLE
                && (magnitude(p) > trig_level || magnitude(y) > trig_level))
            begin
                pitch_best  = '0;
                yaw_best    = '0;
                flick_count = '0;
                flick_phase = fgc_pkg::PH_CAPTURE;
            end
            if (flick_phase == fgc_pkg::PH_CAPTURE)
            begin
                if (magnitude(p) > magnitude(pitch_best))
                    pitch_best = p;
                if (magnitude(y) > magnitude(yaw_best))
                    yaw_best = y;
                flick_count = flick_count + 8'd1;
                wl = (window_len == 0) ? 8'd1 : window_len;
                if (flick_count >= wl)
                begin
                    if (magnitude(pitch_best) >= magnitude(yaw_best))
                        f.gesture = (pitch_best > 0) ? fgc_pkg::G_UP : fgc_pkg::G_DOWN;
                    else
                        f.gesture = (yaw_best > 0) ? fgc_pkg::G_LEFT : fgc_pkg::G_RIGHT;
                    f.pitch_peak = pitch_best;
                    f.yaw_peak   = yaw_best;
                    flick_expected_q.push_back(f);
                    flick_count = '0;
                    flick_phase = (cooldown_len == 0) ? fgc_pkg::PH_IDLE
                                                      : fgc_pkg::PH_COOLDOWN;
                end
            end
        end
    endtask

    // registered handshake so the driver knows whether its item went in
    always @(posedge clk)
        s_took <= s_tvalid && s_tready;

    // sample driver
    always @(negedge clk)
    begin
        if (!s_tvalid || s_took)
        begin
            if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                gap_left--;
            end
            else if (idle_on && pending_samples.size() != 0 && $urandom_range(0, 7) == 0)
            begin
                s_tvalid <= 1'b0;
                gap_left = $urandom_range(1, 4) - 1;
            end
            else if (pending_samples.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_samples.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result receiver: short random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_asked != hold_done)
        begin
            hold_done++;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 4) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : monitor
        flick_t want;
        logic [1:0] got_g;
        logic signed [15:0] got_p;
        logic signed [15:0] got_y;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (fgc_pkg::cfg_reg_t'(cfg_index))
                    fgc_pkg::CFG_THRESHOLD: trig_level   = cfg_data;
                    fgc_pkg::CFG_WINDOW:    window_len   = cfg_data[fgc_pkg::LEN_W-1:0];
                    fgc_pkg::CFG_COOLDOWN:  cooldown_len = cfg_data[fgc_pkg::LEN_W-1:0];
                    default: ;
                endcase
                reg_writes++;
            end
            if (m_tvalid && m_tready)
            begin
                got_g = m_tdata[1:0];
                got_p = m_tdata[17:2];
                got_y = m_tdata[33:18];
                if (flick_expected_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t unexpected flick: expected none, %s %0d pitch %0d yaw %0d",
                             $realtime, "got gesture", got_g, got_p, got_y);
                end
                else
                begin
                    want = flick_expected_q.pop_front();
                    flicks_checked++;
                    if (got_g !== want.gesture || got_p !== want.pitch_peak
                        || got_y !== want.yaw_peak)
                    begin
                        fail_count++;
                        if (fail_count <= 200)
                            $display({"%0t flick mismatch: expected gesture %0d pitch %0d",
                                      " yaw %0d, got gesture %0d pitch %0d yaw %0d"},
                                     $realtime, want.gesture, want.pitch_peak,
                                     want.yaw_peak, got_g, got_p, got_y);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_flick(s_tdata[15:0], s_tdata[31:16]);

            if ((cfg_valid && cfg_ready) || (m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic push_sample(logic [15:0] p, logic [15:0] y);
        pending_samples.push_back({y, p});
        items_queued++;
    endtask

    task automatic write_reg(fgc_pkg::cfg_reg_t idx, int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= fgc_pkg::CFG_DATA_W'(value);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every sample is in, every flick is out, and the pipe is empty.
    task automatic settle();
        while (pending_samples.size() != 0 || s_tvalid)
            @(posedge clk);
        while (flick_expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Mix of quiet, triggering, extreme and fully random rates.
    function automatic logic [15:0] rand_rate(int unsigned level);
        int m;
        case ($urandom_range(0, 11))
            0: m = 0;
            1: return 16'h7FFF;
            2: return 16'h8000;
            3, 4: return 16'($urandom);
            5, 6, 7, 8: m = $urandom_range(0, level);
            9: m = level + $urandom_range(0, 1);
            default: m = $urandom_range(level + 1, 32768);
        endcase
        if (m == 32768 || $urandom_range(0, 1))
            m = -m;
        return 16'(m);
    endfunction

    initial
    begin
        int n;
        int v;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: threshold is strict, 80-sample window, 80-sample cooldown
        push_sample(16'd9825, -16'sd9825);
        push_sample(16'd0, -16'sd9826);
        repeat (79) push_sample(rand_rate(9825), rand_rate(9825));
        repeat (80) push_sample(rand_rate(9825), rand_rate(9825));
        push_sample(16'd100, -16'sd200);
        settle();

        // one-sample windows, no cooldown: every direction and the extremes
        write_reg(fgc_pkg::CFG_THRESHOLD, 1000);
        write_reg(fgc_pkg::CFG_WINDOW, 1);
        write_reg(fgc_pkg::CFG_COOLDOWN, 0);
        push_sample(16'h7FFF, 16'h0000);
        push_sample(16'h8000, 16'h0000);
        push_sample(16'h0000, 16'h7FFF);
        push_sample(16'h0000, 16'h8000);
        push_sample(16'd20000, -16'sd20000);   // equal peaks: pitch wins
        push_sample(-16'sd20000, 16'd20000);
        push_sample(16'h8000, 16'h7FFF);
        push_sample(16'd1000, -16'sd1000);     // at threshold: no trigger
        push_sample(16'd1001, 16'h0000);
        settle();

        // top threshold: only -32768 triggers; window 0 behaves as 1
        write_reg(fgc_pkg::CFG_THRESHOLD, 32767);
        write_reg(fgc_pkg::CFG_WINDOW, 0);
        push_sample(16'h8000, 16'd5);
        push_sample(16'h7FFF, 16'h7FFF);
        push_sample(16'd5, 16'h8000);
        settle();

        // first peak wins a tie, quiet axis, cooldown in between
        write_reg(fgc_pkg::CFG_THRESHOLD, 0);
        write_reg(fgc_pkg::CFG_WINDOW, 3);
        write_reg(fgc_pkg::CFG_COOLDOWN, 2);
        push_sample(16'd12000, 16'd0);
        push_sample(-16'sd12000, 16'd3);
        push_sample(16'd5, -16'sd7);
        push_sample(16'h7FFF, 16'h7FFF);
        push_sample(-16'sd1, 16'd1);
        push_sample(16'd0, -16'sd300);
        push_sample(16'd0, 16'd0);
        push_sample(16'd0, 16'd200);
        push_sample(16'd0, 16'd0);
        push_sample(16'd0, 16'd0);
        settle();

        // shorten the window and the cooldown while they are running
        write_reg(fgc_pkg::CFG_WINDOW, 5);
        push_sample(16'd100, 16'd100);
        push_sample(16'd200, -16'sd50);
        push_sample(16'd0, 16'd0);
        settle();
        write_reg(fgc_pkg::CFG_WINDOW, 2);
        push_sample(-16'sd1, 16'd0);
        push_sample(16'd0, 16'd0);
        settle();
        write_reg(fgc_pkg::CFG_COOLDOWN, 0);
        push_sample(16'd7, 16'd7);
        push_sample(16'd0, 16'd0);
        settle();

        // receiver holds off while a result per sample keeps coming
        write_reg(fgc_pkg::CFG_WINDOW, 1);
        hold_asked++;
        repeat (40) push_sample(rand_rate(0) | 16'd1, rand_rate(0));
        settle();

        while (items_queued < 1430)
        begin
            if ($urandom_range(0, 1))
            begin
                case ($urandom_range(0, 5))
                    0: v = 0;
                    1: v = 32767;
                    2: v = $urandom_range(1, 300);
                    default: v = $urandom_range(0, 32767);
                endcase
                write_reg(fgc_pkg::CFG_THRESHOLD, v);
            end
            if ($urandom_range(0, 1))
            begin
                case ($urandom_range(0, 11))
                    0: v = 0;
                    1: v = 1;
                    2: v = 128;
                    3: v = 255;
                    default: v = $urandom_range(2, 8);
                endcase
                write_reg(fgc_pkg::CFG_WINDOW, v);
            end
            if ($urandom_range(0, 1))
            begin
                case ($urandom_range(0, 11))
                    0, 1: v = 0;
                    2: v = 255;
                    3: v = 128;
                    default: v = $urandom_range(1, 6);
                endcase
                write_reg(fgc_pkg::CFG_COOLDOWN, v);
            end
            idle_on = ($urandom_range(0, 3) != 0);
            n = $urandom_range(30, 90);
            repeat (n) push_sample(rand_rate(trig_level), rand_rate(trig_level));
            settle();
        end

        // closing stretch at full rate on both sides
        idle_on = 1'b0;
        write_reg(fgc_pkg::CFG_THRESHOLD, 5000);
        write_reg(fgc_pkg::CFG_WINDOW, 4);
        write_reg(fgc_pkg::CFG_COOLDOWN, 2);
        repeat (120) push_sample(rand_rate(5000), rand_rate(5000));
        settle();

        $display("run covered %0d samples, %0d flicks checked, %0d register writes",
                 items_queued, flicks_checked, reg_writes);
        $display("settings swept: thresholds 0 to 32767, windows 0 to 255, cooldowns 0 to 255");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
